// File: sv/bank_switch_irq_mapper_core_macros.svh
// Assertion macros shared by the mapper RTL.
`ifndef BANK_SWITCH_IRQ_MAPPER_CORE_MACROS_SVH
`define BANK_SWITCH_IRQ_MAPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define BSIM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bsim assertion failed");
// Checked at every edge, reset included.
`define BSIM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bsim assertion failed");
`else
`define BSIM_ASSERT(lbl, clk, rst_n, prop)
`define BSIM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: sv/bsim_pkg.sv
// Types, codes and constants of the bank switch IRQ mapper.
package bsim_pkg;

    localparam logic [15:0] ADDR_MASK   = 16'hF0CF;
    localparam logic [15:0] ADDR_PRG_A  = 16'h8000;
    localparam logic [15:0] ADDR_PRG_B  = 16'hA000;
    localparam logic [15:0] ADDR_MIRROR = 16'h9000;
    localparam logic [15:0] ADDR_MODE_A = 16'h9002;
    localparam logic [15:0] ADDR_MODE_B = 16'h9080;

    localparam logic [3:0] TOP_CHR_FIRST = 4'hB;
    localparam logic [3:0] TOP_CHR_LAST  = 4'hE;
    localparam logic [3:0] TOP_IRQ       = 4'hF;

    localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
    localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
    localparam logic [1:0] IRQ_CONTROL  = 2'd2;
    localparam logic [1:0] IRQ_ACK      = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PRG    = 2'd1;
    localparam logic [1:0] KIND_CHR    = 2'd2;
    localparam logic [1:0] KIND_MIRROR = 2'd3;

    localparam logic [2:0] SLOT_PRG_LO  = 3'd4;
    localparam logic [2:0] SLOT_PRG_MID = 3'd5;
    localparam logic [2:0] SLOT_PRG_HI  = 3'd6;

    localparam logic [7:0] COUNT_TOP = 8'hFF;

    typedef logic [7:0][7:0] t_chr;

    localparam t_chr CHR_RESET = {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

    typedef struct packed {
        logic        req_type;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [1:0] map_kind;
        logic [2:0] map_slot;
        logic [7:0] map_value;
        logic       irq_out;
    } t_result;

    typedef struct packed {
        t_chr       chr_banks;
        logic [7:0] prg_mode;
        logic [1:0] irq_en;
        logic [7:0] irq_count;
        logic [7:0] irq_reload;
        logic       irq_level;
    } t_state;

endpackage

// File: sv/bsim_ifs.sv
// Valid/ready channel interfaces for mapper requests and results.
interface bsim_item_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, output req_type, output address, output data, input ready);
    modport sink (input valid, input req_type, input address, input data, output ready);
endinterface

interface bsim_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] map_kind;
    logic [2:0] map_slot;
    logic [7:0] map_value;
    logic       irq_out;

    modport source (output valid, output map_kind, output map_slot, output map_value,
                    output irq_out, input ready);
    modport sink (input valid, input map_kind, input map_slot, input map_value,
                  input irq_out, output ready);
endinterface

// File: sv/bsim_decode.sv
// Address decode, state update and result for one request.
module bsim_decode (
    input  bsim_pkg::t_item   i_item,
    input  bsim_pkg::t_state  i_state,
    output bsim_pkg::t_state  o_next,
    output bsim_pkg::t_result o_result
);

    logic [15:0] w_m;
    logic [3:0]  w_top;
    logic [7:0]  w_low;
    logic        w_low_ok;
    logic [1:0]  w_chr_hi;
    logic [2:0]  w_slot;
    logic [7:0]  w_bank;

    assign w_m      = i_item.address & bsim_pkg::ADDR_MASK;
    assign w_top    = w_m[15:12];
    assign w_low    = w_m[7:0];
    assign w_low_ok = (w_low[7:2] == 6'd0);
    assign w_chr_hi = 2'(w_top - bsim_pkg::TOP_CHR_FIRST);
    assign w_slot   = {w_chr_hi, w_low[1]};
    assign w_bank   = w_low[0] ? {i_item.data[3:0], i_state.chr_banks[w_slot][3:0]}
                               : {i_state.chr_banks[w_slot][7:4], i_item.data[3:0]};

    always_comb begin
        o_next             = i_state;
        o_result.map_kind  = bsim_pkg::KIND_NONE;
        o_result.map_slot  = 3'd0;
        o_result.map_value = 8'd0;
        if (i_item.req_type) begin
            // scanline tick
            if (i_state.irq_en[1]) begin
                if (i_state.irq_count == bsim_pkg::COUNT_TOP) begin
                    o_next.irq_count = i_state.irq_reload;
                    o_next.irq_level = 1'b1;
                end else begin
                    o_next.irq_count = i_state.irq_count + 8'd1;
                end
            end
        end else if (w_m == bsim_pkg::ADDR_PRG_A) begin
            o_result.map_kind  = bsim_pkg::KIND_PRG;
            o_result.map_slot  = i_state.prg_mode[1] ? bsim_pkg::SLOT_PRG_HI
                                                     : bsim_pkg::SLOT_PRG_LO;
            o_result.map_value = i_item.data;
        end else if (w_m == bsim_pkg::ADDR_PRG_B) begin
            o_result.map_kind  = bsim_pkg::KIND_PRG;
            o_result.map_slot  = bsim_pkg::SLOT_PRG_MID;
            o_result.map_value = i_item.data;
        end else if (w_m == bsim_pkg::ADDR_MIRROR) begin
            o_result.map_kind  = bsim_pkg::KIND_MIRROR;
            o_result.map_value = {6'd0, i_item.data[1:0]};
        end else if (w_m == bsim_pkg::ADDR_MODE_A || w_m == bsim_pkg::ADDR_MODE_B) begin
            o_next.prg_mode = i_item.data;
        end else if (w_top >= bsim_pkg::TOP_CHR_FIRST && w_top <= bsim_pkg::TOP_CHR_LAST
                     && w_low_ok) begin
            o_next.chr_banks[w_slot] = w_bank;
            o_result.map_kind        = bsim_pkg::KIND_CHR;
            o_result.map_slot        = w_slot;
            o_result.map_value       = w_bank;
        end else if (w_top == bsim_pkg::TOP_IRQ && w_low_ok) begin
            case (w_low[1:0])
                bsim_pkg::IRQ_LATCH_LO: begin
                    o_next.irq_reload = {i_state.irq_reload[7:4], i_item.data[3:0]};
                end
                bsim_pkg::IRQ_LATCH_HI: begin
                    o_next.irq_reload = {i_item.data[3:0], i_state.irq_reload[3:0]};
                end
                bsim_pkg::IRQ_CONTROL: begin
                    o_next.irq_en = i_item.data[1:0];
                    if (i_item.data[1]) begin
                        o_next.irq_count = i_state.irq_reload;
                    end
                end
                bsim_pkg::IRQ_ACK: begin
                    o_next.irq_en = {2{i_state.irq_en[0]}};
                end
                default: begin
                    o_next.irq_en = i_state.irq_en;
                end
            endcase
            o_next.irq_level = 1'b0;
        end
        o_result.irq_out = o_next.irq_level;
    end

endmodule

// File: sv/bsim_regs.sv
// Mapper state registers: character banks, mode and IRQ counter.
`include "bank_switch_irq_mapper_core_macros.svh"

module bsim_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_upd,
    input  bsim_pkg::t_state i_next,
    output bsim_pkg::t_state o_state
);

    bsim_pkg::t_state r_state;
    bsim_pkg::t_state n_state;

    assign n_state = i_upd ? i_next : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.chr_banks  <= bsim_pkg::CHR_RESET;
            r_state.prg_mode   <= 8'd0;
            r_state.irq_en     <= 2'd0;
            r_state.irq_count  <= 8'd0;
            r_state.irq_reload <= 8'd0;
            r_state.irq_level  <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

    `BSIM_ASSERT_ALWAYS(a_rst_level_low, i_clk, !i_rst_n |=> !r_state.irq_level)
    `BSIM_ASSERT(a_hold_when_idle, i_clk, i_rst_n, !i_upd |=> $stable(r_state))
    `BSIM_ASSERT(a_level_rise_on_upd, i_clk, i_rst_n, $rose(r_state.irq_level) |-> $past(i_upd))

endmodule

// File: sv/bank_switch_irq_mapper_core.sv
// Top level of the bank switch IRQ mapper: input register, decode, result register.
// Each request is held in the input register, and its result in the result register, which offers it.
// Throughput: one request per cycle while results are taken; the combinational decode and state update set the pace.
// Reset (i_rst_n low, synchronous): both stages empty, character bank i = i, rest of state 0.
// The IRQ line level is reported with every result.
`include "bank_switch_irq_mapper_core_macros.svh"

module bank_switch_irq_mapper_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bsim_item_if.sink            i_item,
    bsim_result_if.source        o_result
);

    // Input stage: holds one request until the result stage has room.
    logic              r_in_valid;
    logic              n_in_valid;
    bsim_pkg::t_item   r_in;

    // Result stage: holds one result until it is taken.
    logic              r_out_valid;
    logic              n_out_valid;
    bsim_pkg::t_result r_out;

    logic              w_out_free;
    logic              w_adv;
    logic              w_in_xfer;

    bsim_pkg::t_state  w_state;
    bsim_pkg::t_state  w_next;
    bsim_pkg::t_result w_result;

    // Result-stage checks
    logic              w_out_none;
    logic              w_out_mirror;
    logic              w_out_zero;
    logic              w_out_mir_ok;

    // The result stage frees up in the same cycle its content is taken,
    // so a steady stream moves one item per cycle while results are being taken.
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_item.ready = !r_in_valid || w_out_free;
    assign w_in_xfer  = i_item.valid && i_item.ready;

    assign n_in_valid  = w_in_xfer ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
    assign n_out_valid = w_adv ? 1'b1 : (o_result.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in.req_type <= i_item.req_type;
            r_in.address  <= i_item.address;
            r_in.data     <= i_item.data;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // Decode works on the registered request against the current state;
    // state commits in the same edge that captures the result.
    bsim_decode u_decode (
        .i_item   (r_in),
        .i_state  (w_state),
        .o_next   (w_next),
        .o_result (w_result)
    );

    bsim_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_adv),
        .i_next  (w_next),
        .o_state (w_state)
    );

    assign o_result.valid     = r_out_valid;
    assign o_result.map_kind  = r_out.map_kind;
    assign o_result.map_slot  = r_out.map_slot;
    assign o_result.map_value = r_out.map_value;
    assign o_result.irq_out   = r_out.irq_out;

    assign w_out_none   = r_out_valid && (r_out.map_kind == bsim_pkg::KIND_NONE);
    assign w_out_mirror = r_out_valid && (r_out.map_kind == bsim_pkg::KIND_MIRROR);
    assign w_out_zero   = (r_out.map_slot == 3'd0) && (r_out.map_value == 8'd0);
    assign w_out_mir_ok = (r_out.map_slot == 3'd0) && (r_out.map_value[7:2] == 6'd0);

    `BSIM_ASSERT(a_adv_fills_out, i_clk, i_rst_n, w_adv |=> r_out_valid)
    `BSIM_ASSERT(a_none_is_zero, i_clk, i_rst_n, w_out_none |-> w_out_zero)
    `BSIM_ASSERT(a_mirror_range, i_clk, i_rst_n, w_out_mirror |-> w_out_mir_ok)

endmodule

// File: test/bank_switch_irq_mapper_core_test.sv
// Self-checking testbench for bank_switch_irq_mapper_core: directed table, then random requests.
module bank_switch_irq_mapper_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Request kinds on the input channel.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Directed rows either carry a hand-written result or defer to the predictor.
    localparam logic PIN  = 1'b1;
    localparam logic CALC = 1'b0;

    localparam bsim_pkg::t_result NO_CHANGE = {bsim_pkg::KIND_NONE, 3'd0, 8'h00, 1'b0};

    localparam int RANDOM_COUNT = 1900;
    localparam int QUIET_TAIL   = 250;     // last random requests run with no idling
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 4;       // margin after every result is back

    typedef struct packed {
        logic              pinned;
        bsim_pkg::t_item   req;
        bsim_pkg::t_result want;
    } t_row;

    // Directed table. Walks the program windows in both modes, mirroring, mode writes,
    // character nibbles, unmapped decodes and the interrupt counter. The latch is set to
    // 0xFF so that every enabled tick wraps and raises the line.
    localparam t_row DIRECTED_ROWS [25] = '{
        // tick right after reset: counter disabled, nothing moves
        {PIN,  REQ_TICK,  16'hFFFF, 8'hFF, NO_CHANGE},
        // program window 4 (mode bit 1 clear), then window 5
        {PIN,  REQ_WRITE, 16'h8000, 8'hFF, bsim_pkg::KIND_PRG, bsim_pkg::SLOT_PRG_LO,
         8'hFF, 1'b0},
        {PIN,  REQ_WRITE, 16'hA000, 8'h00, bsim_pkg::KIND_PRG, bsim_pkg::SLOT_PRG_MID,
         8'h00, 1'b0},
        // mirroring keeps only the low two bits of data
        {PIN,  REQ_WRITE, 16'h9000, 8'hFF, bsim_pkg::KIND_MIRROR, 3'd0, 8'h03, 1'b0},
        // mode write through the first alias moves 0x8000 writes to window 6
        {PIN,  REQ_WRITE, 16'h9002, 8'h02, NO_CHANGE},
        {PIN,  REQ_WRITE, 16'h8000, 8'hAB, bsim_pkg::KIND_PRG, bsim_pkg::SLOT_PRG_HI,
         8'hAB, 1'b0},
        // second alias clears the mode again
        {PIN,  REQ_WRITE, 16'h9080, 8'h00, NO_CHANGE},
        // address bits outside the decode mask are ignored
        {PIN,  REQ_WRITE, 16'h8F30, 8'h5A, bsim_pkg::KIND_PRG, bsim_pkg::SLOT_PRG_LO,
         8'h5A, 1'b0},
        // character nibbles: low then high of slot 0, high of slot 7, low of slot 3
        {CALC, REQ_WRITE, 16'hB000, 8'hF5, NO_CHANGE},
        {CALC, REQ_WRITE, 16'hB001, 8'hFA, NO_CHANGE},
        {CALC, REQ_WRITE, 16'hE003, 8'h0F, NO_CHANGE},
        {CALC, REQ_WRITE, 16'hCF32, 8'h00, NO_CHANGE},
        // unmapped writes, including a character page with low bits past 3
        {PIN,  REQ_WRITE, 16'h0000, 8'hFF, NO_CHANGE},
        {PIN,  REQ_WRITE, 16'hB004, 8'h33, NO_CHANGE},
        // latch = 0xFF, enable with reload
        {PIN,  REQ_WRITE, 16'hF000, 8'hFF, NO_CHANGE},
        {PIN,  REQ_WRITE, 16'hF001, 8'hFF, NO_CHANGE},
        {PIN,  REQ_WRITE, 16'hF002, 8'h03, NO_CHANGE},
        // counter at 0xFF: wrap and raise the line
        {PIN,  REQ_TICK,  16'h0000, 8'h00, bsim_pkg::KIND_NONE, 3'd0, 8'h00, 1'b1},
        // unmapped write in the interrupt page leaves the line alone
        {PIN,  REQ_WRITE, 16'hF004, 8'h00, bsim_pkg::KIND_NONE, 3'd0, 8'h00, 1'b1},
        // acknowledge clears the line, enable stays on
        {PIN,  REQ_WRITE, 16'hF003, 8'h00, NO_CHANGE},
        {PIN,  REQ_TICK,  16'h0000, 8'h00, bsim_pkg::KIND_NONE, 3'd0, 8'h00, 1'b1},
        // control with only the after-ack bit: counter stops
        {PIN,  REQ_WRITE, 16'hF002, 8'h01, NO_CHANGE},
        {PIN,  REQ_TICK,  16'h0000, 8'h00, NO_CHANGE},
        // acknowledge copies the after-ack bit into the enable
        {PIN,  REQ_WRITE, 16'hF003, 8'hFF, NO_CHANGE},
        {PIN,  REQ_TICK,  16'h0000, 8'h00, bsim_pkg::KIND_NONE, 3'd0, 8'h00, 1'b1}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsim_item_if   item_ch ();
    bsim_result_if result_ch ();

    bank_switch_irq_mapper_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Side band that travels with each request: a pinned expectation from the table.
    logic              row_pinned;
    bsim_pkg::t_result row_want;

    // Mapper state as the predictor sees it.
    logic [7:0] chr_model [8];
    logic [7:0] mode_model;
    logic [1:0] irq_en_model;
    logic [7:0] irq_count_model;
    logic [7:0] irq_latch_model;
    logic       irq_line_model;

    bsim_pkg::t_result pending_maps [$];

    int  cycle_count = 0;
    int  fail_count = 0;
    int  request_count = 0;
    int  bank_updates = 0;
    int  irq_raises = 0;
    logic last_irq = 1'b0;
    bit  quiet_tail = 1'b0;

    // Applies one request to the model state and returns the result it should produce.
    function automatic bsim_pkg::t_result predict_mapping(bsim_pkg::t_item req);
        bsim_pkg::t_result r;
        logic [15:0] m;
        logic [3:0]  top;
        logic [7:0]  low;
        logic [3:0]  page;
        logic [2:0]  slot;
        r    = '0;
        m    = req.address & bsim_pkg::ADDR_MASK;
        top  = m[15:12];
        low  = m[7:0];
        page = top - bsim_pkg::TOP_CHR_FIRST;
        slot = {page[1:0], low[1]};
        if (req.req_type == REQ_TICK) begin
            if (irq_en_model[1]) begin
                if (irq_count_model == bsim_pkg::COUNT_TOP) begin
                    irq_count_model = irq_latch_model;
                    irq_line_model  = 1'b1;
                end else begin
                    irq_count_model = irq_count_model + 8'd1;
                end
            end
        end else if (m == bsim_pkg::ADDR_PRG_A) begin
            r.map_kind  = bsim_pkg::KIND_PRG;
            r.map_slot  = mode_model[1] ? bsim_pkg::SLOT_PRG_HI : bsim_pkg::SLOT_PRG_LO;
            r.map_value = req.data;
        end else if (m == bsim_pkg::ADDR_PRG_B) begin
            r.map_kind  = bsim_pkg::KIND_PRG;
            r.map_slot  = bsim_pkg::SLOT_PRG_MID;
            r.map_value = req.data;
        end else if (m == bsim_pkg::ADDR_MIRROR) begin
            r.map_kind  = bsim_pkg::KIND_MIRROR;
            r.map_value = {6'd0, req.data[1:0]};
        end else if (m == bsim_pkg::ADDR_MODE_A || m == bsim_pkg::ADDR_MODE_B) begin
            mode_model = req.data;
        end else if (top >= bsim_pkg::TOP_CHR_FIRST && top <= bsim_pkg::TOP_CHR_LAST
                     && low <= 8'd3) begin
            // bit 0 of the address picks the nibble, bit 1 the odd slot of the pair
            if (low[0])
                chr_model[slot][7:4] = req.data[3:0];
            else
                chr_model[slot][3:0] = req.data[3:0];
            r.map_kind  = bsim_pkg::KIND_CHR;
            r.map_slot  = slot;
            r.map_value = chr_model[slot];
        end else if (top == bsim_pkg::TOP_IRQ && low <= 8'd3) begin
            case (low[1:0])
                bsim_pkg::IRQ_LATCH_LO: irq_latch_model[3:0] = req.data[3:0];
                bsim_pkg::IRQ_LATCH_HI: irq_latch_model[7:4] = req.data[3:0];
                bsim_pkg::IRQ_CONTROL: begin
                    irq_en_model = req.data[1:0];
                    if (irq_en_model[1])
                        irq_count_model = irq_latch_model;
                end
                bsim_pkg::IRQ_ACK: irq_en_model[1] = irq_en_model[0];
                default: ;
            endcase
            irq_line_model = 1'b0;
        end
        r.irq_out = irq_line_model;
        return r;
    endfunction

    // Mostly well-formed decodes with junk in the ignored address bits; ticks are
    // frequent so the counter actually wraps, and the latch leans toward high values.
    function automatic bsim_pkg::t_item random_request();
        bsim_pkg::t_item req;
        int          pick;
        logic [15:0] noise;
        logic [3:0]  top;
        logic [1:0]  reg_sel;
        req.req_type = REQ_WRITE;
        req.data     = 8'($urandom_range(0, 255));
        noise        = 16'($urandom_range(0, 65535)) & ~bsim_pkg::ADDR_MASK;
        pick         = $urandom_range(0, 99);
        if (pick < 35) begin
            req.req_type = REQ_TICK;
            req.address  = 16'($urandom_range(0, 65535));
        end else if (pick < 45) begin
            req.address = ($urandom_range(0, 1) ? bsim_pkg::ADDR_PRG_A
                                                : bsim_pkg::ADDR_PRG_B) | noise;
        end else if (pick < 50) begin
            req.address = bsim_pkg::ADDR_MIRROR | noise;
        end else if (pick < 55) begin
            req.address = ($urandom_range(0, 1) ? bsim_pkg::ADDR_MODE_A
                                                : bsim_pkg::ADDR_MODE_B) | noise;
        end else if (pick < 72) begin
            top         = bsim_pkg::TOP_CHR_FIRST + 4'($urandom_range(0, 3));
            req.address = {top, 12'h000} | 16'($urandom_range(0, 3)) | noise;
        end else if (pick < 88) begin
            reg_sel = 2'($urandom_range(0, 3));
            if (reg_sel == bsim_pkg::IRQ_CONTROL && $urandom_range(0, 3) != 0)
                req.data[1] = 1'b1;
            if (reg_sel == bsim_pkg::IRQ_LATCH_HI && $urandom_range(0, 1) != 0)
                req.data[3:0] = 4'hF;
            req.address = {bsim_pkg::TOP_IRQ, 10'd0, reg_sel} | noise;
        end else begin
            req.address = 16'($urandom_range(0, 65535));
        end
        return req;
    endfunction

    // Offer one request and hold it until the transfer edge.
    task automatic offer_request(bsim_pkg::t_item req, logic pinned, bsim_pkg::t_result want);
        item_ch.valid    <= 1'b1;
        item_ch.req_type <= req.req_type;
        item_ch.address  <= req.address;
        item_ch.data     <= req.data;
        row_pinned       <= pinned;
        row_want         <= want;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Stop sending until every outstanding result has come back. The first edge
    // lets the monitor record the last transfer before the queue is looked at.
    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_maps.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus: reset, directed table, random requests, drain, verdict.
    initial begin
        item_ch.valid    = 1'b0;
        item_ch.req_type = REQ_WRITE;
        item_ch.address  = '0;
        item_ch.data     = '0;
        row_pinned       = CALC;
        row_want         = NO_CHANGE;
        for (int i = 0; i < 8; i++)
            chr_model[i] = 8'(i);
        mode_model      = '0;
        irq_en_model    = '0;
        irq_count_model = '0;
        irq_latch_model = '0;
        irq_line_model  = 1'b0;

        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            maybe_idle();
            offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].pinned,
                          DIRECTED_ROWS[i].want);
        end
        wait_for_results();

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n == RANDOM_COUNT / 2)
                wait_for_results();
            if (n >= RANDOM_COUNT - QUIET_TAIL)
                quiet_tail = 1'b1;
            maybe_idle();
            offer_request(random_request(), CALC, NO_CHANGE);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests transferred: %0d bank or mirroring updates, %0d IRQ assertions.",
                 request_count, bank_updates, irq_raises);
        if (fail_count == 0)
            $display("bank_switch_irq_mapper_core: match");
        else
            $display("bank_switch_irq_mapper_core: mismatch");
        $finish;
    end

    // Result side: ready drops in random bursts; no new burst starts during the quiet tail.
    initial begin
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: record each request transfer, then check each result transfer
    // against the oldest pending expectation.
    always @(posedge i_clk) begin
        bsim_pkg::t_item   req;
        bsim_pkg::t_result predicted;
        bsim_pkg::t_result want;
        bsim_pkg::t_result got;
        cycle_count++;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                req       = {item_ch.req_type, item_ch.address, item_ch.data};
                // the predictor always runs so its state tracks the block
                predicted = predict_mapping(req);
                pending_maps.push_back(row_pinned ? row_want : predicted);
                request_count++;
            end
            if (result_ch.valid && result_ch.ready) begin
                got = {result_ch.map_kind, result_ch.map_slot, result_ch.map_value,
                       result_ch.irq_out};
                if (pending_maps.size() == 0) begin
                    $error("result transfer with nothing pending");
                    fail_count++;
                end else begin
                    want = pending_maps.pop_front();
                    if (got.map_kind !== want.map_kind) begin
                        $error("map_kind: expected %0d, got %0d", want.map_kind, got.map_kind);
                        fail_count++;
                    end
                    if (got.map_slot !== want.map_slot) begin
                        $error("map_slot: expected %0d, got %0d", want.map_slot, got.map_slot);
                        fail_count++;
                    end
                    if (got.map_value !== want.map_value) begin
                        $error("map_value: expected 0x%02h, got 0x%02h",
                               want.map_value, got.map_value);
                        fail_count++;
                    end
                    if (got.irq_out !== want.irq_out) begin
                        $error("irq_out: expected %0d, got %0d", want.irq_out, got.irq_out);
                        fail_count++;
                    end
                end
                if (got.map_kind != bsim_pkg::KIND_NONE)
                    bank_updates++;
                if (got.irq_out && !last_irq)
                    irq_raises++;
                last_irq = got.irq_out;
            end
        end
    end

    // Watchdog on the cycle counter.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("bank_switch_irq_mapper_core: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/bsim_pkg.sv
sv/bsim_ifs.sv
sv/bsim_decode.sv
sv/bsim_regs.sv
sv/bank_switch_irq_mapper_core.sv
test/bank_switch_irq_mapper_core_test.sv
